/* sv/block_base_fee_predictor_top_assert.svh */
// ----------------------------------------------------------------------------
// Base fee predictor assertion macros
// Short forms for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BASE_FEE_PREDICTOR_TOP_ASSERT_SVH
`define BLOCK_BASE_FEE_PREDICTOR_TOP_ASSERT_SVH

// same-cycle implication
`define BFP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bfp_pkg.sv */
// ----------------------------------------------------------------------------
// bfp_pkg
// Widths, codes, step counts and shared types of the base fee predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

   localparam int WORD_W     = 64;
   localparam int WIDE_W     = 2 * WORD_W;
   localparam int FEE_SHIFT  = 3;
   localparam int LIMIT_SHIFT = 10;

   localparam int MUL_STEPS  = WORD_W;
   localparam int DIV_STEPS  = WIDE_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   localparam logic [1:0] OP_HEADER  = 2'd0;
   localparam logic [1:0] OP_LEGACY  = 2'd1;
   localparam logic [1:0] OP_DYNAMIC = 2'd2;
   localparam logic [1:0] OP_BLOB    = 2'd3;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NUMBER_MISS = 2'd1;
   localparam logic [1:0] ST_FEE_MISS    = 2'd2;
   localparam logic [1:0] ST_ZERO_TARGET = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_MUL    = 6'b000100,
      S_DIV    = 6'b001000,
      S_ADJ    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

endpackage

`default_nettype wire

/* sv/bfp_if.sv */
// ----------------------------------------------------------------------------
// bfp channel interfaces
// Valid/ready channels for header and transaction items and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfp_req_if
   import bfp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [WORD_W-1:0] block_number;
   logic [WORD_W-1:0] gas_lim;
   logic [WORD_W-1:0] gas_spent;
   logic [WORD_W-1:0] header_base_fee;
   logic [WORD_W-1:0] tx_price;
   logic [WORD_W-1:0] max_fee_per_gas;
   logic [WORD_W-1:0] max_priority_per_gas;

   modport source (
      output valid, opcode, block_number, gas_lim, gas_spent, header_base_fee,
             tx_price, max_fee_per_gas, max_priority_per_gas,
      input  ready
   );
   modport sink (
      input  valid, opcode, block_number, gas_lim, gas_spent, header_base_fee,
             tx_price, max_fee_per_gas, max_priority_per_gas,
      output ready
   );
endinterface

interface bfp_rsp_if
   import bfp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [WORD_W-1:0] next_base_fee;
   logic [WORD_W-1:0] next_gas_limit;
   logic [WORD_W-1:0] tip_fee;

   modport source (
      output valid, status, next_base_fee, next_gas_limit, tip_fee,
      input  ready
   );
   modport sink (
      input  valid, status, next_base_fee, next_gas_limit, tip_fee,
      output ready
   );
endinterface

`default_nettype wire

/* sv/bfp_mul.sv */
// ----------------------------------------------------------------------------
// bfp_mul
// Serial shift-add multiplier, one multiplier bit per cycle, full product.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_mul
   import bfp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [WORD_W-1:0]   multiplicand,
   input  wire logic [WORD_W-1:0]   multiplier,
   output logic      [WIDE_W-1:0]   product,
   output unit_stat_type            stat
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    mcand_ff, mcand_in;
   logic [WIDE_W-1:0]    prod_ff, prod_in;
   logic [WORD_W:0]      sum;
   logic                 last;

   assign last = (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1));
   assign sum  = {1'b0, prod_ff[WIDE_W-1:WORD_W]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : {(WORD_W + 1){1'b0}});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = multiplicand;
         prod_in  = {{WORD_W{1'b0}}, multiplier};
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[WORD_W-1:1]};
         cnt_in  = cnt_ff + MUL_CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign product   = prod_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

/* sv/bfp_div.sv */
// ----------------------------------------------------------------------------
// bfp_div
// Serial restoring divider, one quotient bit per cycle, wide dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_div
   import bfp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [WIDE_W-1:0]   dividend,
   input  wire logic [WORD_W-1:0]   divisor,
   output logic      [WIDE_W-1:0]   quotient,
   output unit_stat_type            stat
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    dsor_ff, dsor_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WIDE_W-1:0]    work_ff, work_in;
   logic [WORD_W-1:0]    shifted;
   logic [WORD_W:0]      trial;
   logic                 fits;
   logic                 last;

   assign last    = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign shifted = {rem_ff[WORD_W-2:0], work_ff[WIDE_W-1]};
   assign trial   = {rem_ff[WORD_W-1], shifted} - {1'b0, dsor_ff};
   assign fits    = ~trial[WORD_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dsor_in = dsor_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dsor_in = divisor;
         rem_in  = '0;
         work_in = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[WORD_W-1:0] : shifted;
         work_in = {work_ff[WIDE_W-2:0], fits};
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dsor_ff <= dsor_in;
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign quotient  = work_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

/* sv/block_base_fee_predictor_top.sv */
// Transaction, blob and fee-keeping header items go from the input registers through
// the check and finish states to the result register. Headers that move the fee also
// run 64 multiply and 128 divide steps through the serial units, then adjust and finish.
// One item at a time: a new transfer is taken only in the idle state, once the
// previous result sits in the output register.
// Synchronous reset clears the expected number, base fee and gas limit to zero.
// ----------------------------------------------------------------------------
// block_base_fee_predictor_top
// Header checking, next base fee and gas limit prediction, transaction tips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_base_fee_predictor_top_assert.svh"

module block_base_fee_predictor_top
   import bfp_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   bfp_req_if.sink    req_chan,
   bfp_rsp_if.source  rsp_chan
);

   state_type          state_ff, state_in;

   logic [1:0]         op_ff;
   logic [WORD_W-1:0]  number_ff, limit_ff, used_ff, fee_ff;
   logic [WORD_W-1:0]  price_ff, cap_ff, tipcap_ff;

   logic [WORD_W-1:0]  exp_number_ff, exp_number_in;
   logic [WORD_W-1:0]  exp_fee_ff, exp_fee_in;
   logic [WORD_W-1:0]  pred_limit_ff, pred_limit_in;

   logic [1:0]         status_ff, status_in;
   logic [WORD_W-1:0]  tip_ff, tip_in;
   logic               up_ff, up_in;
   logic [WORD_W-1:0]  fee_new_ff, fee_new_in;
   logic [WORD_W-1:0]  limit_new_ff, limit_new_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_fee_ff, rsp_fee_in;
   logic [WORD_W-1:0]  rsp_limit_ff, rsp_limit_in;
   logic [WORD_W-1:0]  rsp_tip_ff, rsp_tip_in;

   logic               accept;
   logic               is_header;
   logic               rsp_free;
   logic               finish;
   logic [WORD_W-1:0]  target;
   logic               gas_up, gas_down, target_zero;
   logic [WORD_W-1:0]  gas_diff;
   logic [WORD_W-1:0]  limit_step;
   logic [WORD_W:0]    limit_sum;
   logic [WORD_W-1:0]  price_tip, cap_tip;

   logic               mul_start, div_start;
   logic [WIDE_W-1:0]  product, quotient;
   unit_stat_type      mul_stat, div_stat;

   logic               quo_sat;
   logic [WORD_W-1:0]  quo_fee, quo_fee_min;
   logic [WORD_W:0]    fee_sum;

   assign accept    = req_chan.valid && req_chan.ready;
   assign is_header = (op_ff == OP_HEADER);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign finish    = (state_ff == S_FINISH) && rsp_free;

   assign target      = {1'b0, limit_ff[WORD_W-1:1]};
   assign target_zero = (target == '0);
   assign gas_up      = used_ff > target;
   assign gas_down    = used_ff < target;
   assign gas_diff    = gas_up ? (used_ff - target) : (target - used_ff);
   assign limit_step  = limit_ff >> LIMIT_SHIFT;
   assign limit_sum   = {1'b0, limit_ff} + {1'b0, limit_step};

   assign price_tip = (price_ff > exp_fee_ff) ? (price_ff - exp_fee_ff) : '0;
   assign cap_tip   = (cap_ff > exp_fee_ff) ? (cap_ff - exp_fee_ff) : '0;

   assign mul_start = (state_ff == S_CHECK) && is_header && (gas_up || gas_down)
                    && !target_zero;
   assign div_start = (state_ff == S_MUL) && mul_stat.done;

   bfp_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (fee_ff),
      .multiplier   (gas_diff),
      .product      (product),
      .stat         (mul_stat)
   );

   bfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (target),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign quo_sat     = |quotient[WIDE_W-1:WORD_W+FEE_SHIFT];
   assign quo_fee     = quo_sat ? ALL_ONES : quotient[WORD_W+FEE_SHIFT-1:FEE_SHIFT];
   assign quo_fee_min = (quo_fee == '0) ? WORD_W'(1) : quo_fee;
   assign fee_sum     = {1'b0, fee_ff} + {1'b0, quo_fee_min};

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      tip_in        = tip_ff;
      up_in         = up_ff;
      fee_new_in    = fee_new_ff;
      limit_new_in  = limit_new_ff;
      exp_number_in = exp_number_ff;
      exp_fee_in    = exp_fee_ff;
      pred_limit_in = pred_limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fee_in    = rsp_fee_ff;
      rsp_limit_in  = rsp_limit_ff;
      rsp_tip_in    = rsp_tip_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = ST_OK;
            tip_in    = '0;
            up_in     = gas_up;
            fee_new_in = fee_ff;
            if (gas_up) begin
               limit_new_in = limit_sum[WORD_W] ? ALL_ONES : limit_sum[WORD_W-1:0];
            end else if (gas_down) begin
               limit_new_in = limit_ff - limit_step;
            end else begin
               limit_new_in = limit_ff;
            end
            case (op_ff)
               OP_HEADER: begin
                  if (fee_ff != exp_fee_ff) begin
                     status_in = ST_FEE_MISS;
                  end else if (number_ff != exp_number_ff) begin
                     status_in = ST_NUMBER_MISS;
                  end else if (target_zero) begin
                     status_in = ST_ZERO_TARGET;
                  end
               end
               OP_LEGACY: begin
                  tip_in = price_tip;
               end
               OP_DYNAMIC: begin
                  tip_in = (cap_tip > tipcap_ff) ? tipcap_ff : cap_tip;
               end
               default: begin
                  tip_in = '0;
               end
            endcase
            state_in = mul_start ? S_MUL : S_FINISH;
         end
         S_MUL: begin
            if (mul_stat.done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            if (up_ff) begin
               fee_new_in = fee_sum[WORD_W] ? ALL_ONES : fee_sum[WORD_W-1:0];
            end else begin
               fee_new_in = fee_ff - quo_fee;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_tip_in    = tip_ff;
               if (is_header) begin
                  exp_number_in = number_ff + WORD_W'(1);
                  exp_fee_in    = fee_new_ff;
                  pred_limit_in = limit_new_ff;
                  rsp_fee_in    = fee_new_ff;
                  rsp_limit_in  = limit_new_ff;
               end else begin
                  rsp_fee_in    = exp_fee_ff;
                  rsp_limit_in  = pred_limit_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         exp_number_ff <= '0;
         exp_fee_ff    <= '0;
         pred_limit_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         exp_number_ff <= exp_number_in;
         exp_fee_ff    <= exp_fee_in;
         pred_limit_ff <= pred_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_chan.opcode;
         number_ff <= req_chan.block_number;
         limit_ff  <= req_chan.gas_lim;
         used_ff   <= req_chan.gas_spent;
         fee_ff    <= req_chan.header_base_fee;
         price_ff  <= req_chan.tx_price;
         cap_ff    <= req_chan.max_fee_per_gas;
         tipcap_ff <= req_chan.max_priority_per_gas;
      end
      status_ff     <= status_in;
      tip_ff        <= tip_in;
      up_ff         <= up_in;
      fee_new_ff    <= fee_new_in;
      limit_new_ff  <= limit_new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fee_ff    <= rsp_fee_in;
      rsp_limit_ff  <= rsp_limit_in;
      rsp_tip_ff    <= rsp_tip_in;
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.next_base_fee  = rsp_fee_ff;
   assign rsp_chan.next_gas_limit = rsp_limit_ff;
   assign rsp_chan.tip_fee        = rsp_tip_ff;

   `BFP_ASSERT_SAME(a_units_exclusive, mul_stat.busy, !div_stat.busy,
      "multiplier and divider busy together")
   `BFP_ASSERT_SAME(a_no_mul_zero_target, mul_start, !target_zero && is_header,
      "fee multiply started without a gas target")
   `BFP_ASSERT_NEXT(a_tx_keeps_state, finish && !is_header,
      $stable(exp_fee_ff) && $stable(pred_limit_ff) && $stable(exp_number_ff),
      "transaction item changed the stored header state")
   `BFP_ASSERT_SAME(a_rsp_from_finish, $rose(rsp_valid_ff), $past(finish),
      "result raised outside the finish step")
   `BFP_ASSERT_NEXT(a_div_after_mul, div_start, div_stat.busy && !mul_stat.busy,
      "divider not running after multiply hand-off")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base fee predictor testbench
// Drives header, transaction and blob items into the predictor over its
// valid/ready input channel and checks every result field against a fee
// market model kept in the bench. Random idling on both sides, one long
// result stall to back up the input, and mostly well-chained headers.
// ----------------------------------------------------------------------------
module testbench
   import bfp_pkg::*;
();

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int RANDOM_ITEMS  = 1330;
   localparam int DRAIN_CYCLES  = 250;
   localparam int STALL_CYCLES  = 400;
   localparam int STALL_AFTER   = 300;
   localparam int QUIET_START   = 40_000;
   localparam int QUIET_END     = 70_000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] block_number;
      logic [63:0] gas_lim;
      logic [63:0] gas_spent;
      logic [63:0] header_base_fee;
      logic [63:0] tx_price;
      logic [63:0] max_fee_per_gas;
      logic [63:0] max_priority_per_gas;
   } fee_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] next_base_fee;
      logic [63:0] next_gas_limit;
      logic [63:0] tip_fee;
   } fee_result_type;

   typedef struct packed {
      logic [63:0] number;
      logic [63:0] cur_fee;
      logic [63:0] gas_lim;
   } fee_chain_type;

   logic clock;
   logic reset;

   bfp_req_if req_bus ();
   bfp_rsp_if rsp_bus ();

   block_base_fee_predictor_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   fee_item_type   pending_items[$];
   fee_result_type expected_results[$];
   fee_chain_type  model_chain;
   fee_chain_type  plan_chain;
   fee_item_type   offered_item;
   int             cycle_count;
   int             fail_count;
   int             results_seen;
   int             stall_left;
   logic           stall_done;
   logic           quiet;

   assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Advance the fee chain by one item and return the result it produces.
   function automatic void apply_item(input fee_item_type it, inout fee_chain_type st,
                                      output fee_result_type res);
      logic [63:0]  target;
      logic [63:0]  delta;
      logic [63:0]  step;
      logic [63:0]  q;
      logic [63:0]  tip;
      logic [63:0]  new_fee;
      logic [63:0]  new_limit;
      logic [127:0] prod;
      logic [127:0] quot;
      logic [1:0]   status;
      status = ST_OK;
      tip    = '0;
      case (it.opcode)
         OP_HEADER: begin
            target    = it.gas_lim >> 1;
            new_fee   = it.header_base_fee;
            new_limit = it.gas_lim;
            if (it.header_base_fee != st.cur_fee) begin
               status = ST_FEE_MISS;
            end else if (it.block_number != st.number) begin
               status = ST_NUMBER_MISS;
            end else if (target == 0) begin
               status = ST_ZERO_TARGET;
            end
            delta = (it.gas_spent > target) ? it.gas_spent - target : target - it.gas_spent;
            q = '0;
            if (target != 0) begin
               prod = {64'd0, it.header_base_fee} * {64'd0, delta};
               quot = (prod / {64'd0, target}) >> FEE_SHIFT;
               q    = (quot[127:64] != 0) ? ALL_ONES : quot[63:0];
            end
            if (it.gas_spent > target) begin
               step      = it.gas_lim >> LIMIT_SHIFT;
               new_limit = (it.gas_lim > ALL_ONES - step) ? ALL_ONES : it.gas_lim + step;
               if (target != 0) begin
                  if (q == 0) q = 64'd1;
                  new_fee = (it.header_base_fee > ALL_ONES - q) ?
                            ALL_ONES : it.header_base_fee + q;
               end
            end else if (it.gas_spent < target) begin
               new_limit = it.gas_lim - (it.gas_lim >> LIMIT_SHIFT);
               new_fee   = it.header_base_fee - q;
            end
            st.cur_fee = new_fee;
            st.gas_lim = new_limit;
            st.number  = it.block_number + 64'd1;
         end
         OP_LEGACY: begin
            if (it.tx_price > st.cur_fee) tip = it.tx_price - st.cur_fee;
         end
         OP_DYNAMIC: begin
            if (it.max_fee_per_gas > st.cur_fee) tip = it.max_fee_per_gas - st.cur_fee;
            if (tip > it.max_priority_per_gas) tip = it.max_priority_per_gas;
         end
         default: begin
         end
      endcase
      res.status         = status;
      res.next_base_fee  = st.cur_fee;
      res.next_gas_limit = st.gas_lim;
      res.tip_fee        = tip;
   endfunction

   function automatic fee_item_type header_item(logic [63:0] number, logic [63:0] limit,
                                                logic [63:0] used, logic [63:0] fee);
      fee_item_type it;
      it.opcode               = OP_HEADER;
      it.block_number         = number;
      it.gas_lim              = limit;
      it.gas_spent            = used;
      it.header_base_fee      = fee;
      it.tx_price             = rand64();
      it.max_fee_per_gas      = rand64();
      it.max_priority_per_gas = rand64();
      return it;
   endfunction

   function automatic fee_item_type tx_item(logic [1:0] op, logic [63:0] price,
                                            logic [63:0] cap, logic [63:0] tip_cap);
      fee_item_type it;
      it.opcode               = op;
      it.block_number         = rand64();
      it.gas_lim              = rand64();
      it.gas_spent            = rand64();
      it.header_base_fee      = rand64();
      it.tx_price             = price;
      it.max_fee_per_gas      = cap;
      it.max_priority_per_gas = tip_cap;
      return it;
   endfunction

   // Queue an item and track the chain so later headers can follow it.
   task automatic queue_item(input fee_item_type it);
      fee_result_type unused_res;
      apply_item(it, plan_chain, unused_res);
      pending_items.insert(pending_items.size(), it);
   endtask

   function automatic logic [63:0] pick_tx_value(logic [63:0] base);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30)      return base + 64'($urandom_range(0, 1000));
      else if (sel < 50) return base - 64'($urandom_range(0, 1000));
      else if (sel < 80) return rand64();
      else if (sel < 90) return '0;
      else               return ALL_ONES;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Driver: hold an offer until it transfers, then take the next pending item.
   always @(posedge clock) begin : drive_proc
      fee_result_type res;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_item(offered_item, model_chain, res);
            expected_results.insert(expected_results.size(), res);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 &&
                (quiet || stall_left != 0 || $urandom_range(0, 99) >= 20)) begin
               offered_item                 = pending_items.pop_front();
               req_bus.valid                <= 1'b1;
               req_bus.opcode               <= offered_item.opcode;
               req_bus.block_number         <= offered_item.block_number;
               req_bus.gas_lim              <= offered_item.gas_lim;
               req_bus.gas_spent            <= offered_item.gas_spent;
               req_bus.header_base_fee      <= offered_item.header_base_fee;
               req_bus.tx_price             <= offered_item.tx_price;
               req_bus.max_fee_per_gas      <= offered_item.max_fee_per_gas;
               req_bus.max_priority_per_gas <= offered_item.max_priority_per_gas;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin : monitor_proc
      fee_result_type exp_res;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         stall_done    <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
               $error("result with no expectation: status %0d fee %0h", rsp_bus.status,
                      rsp_bus.next_base_fee);
               fail_count = fail_count + 1;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_bus.status !== exp_res.status) begin
                  $error("status: expected %0d actual %0d", exp_res.status, rsp_bus.status);
                  fail_count = fail_count + 1;
               end
               if (rsp_bus.next_base_fee !== exp_res.next_base_fee) begin
                  $error("next_base_fee: expected %0h actual %0h", exp_res.next_base_fee,
                         rsp_bus.next_base_fee);
                  fail_count = fail_count + 1;
               end
               if (rsp_bus.next_gas_limit !== exp_res.next_gas_limit) begin
                  $error("next_gas_limit: expected %0h actual %0h", exp_res.next_gas_limit,
                         rsp_bus.next_gas_limit);
                  fail_count = fail_count + 1;
               end
               if (rsp_bus.tip_fee !== exp_res.tip_fee) begin
                  $error("tip_fee: expected %0h actual %0h", exp_res.tip_fee,
                         rsp_bus.tip_fee);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
         end else if (!stall_done && results_seen >= STALL_AFTER) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= STALL_CYCLES;
            stall_done    <= 1'b1;
         end else begin
            rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   initial begin : stimulus
      int          sel;
      logic [63:0] limit;
      logic [63:0] target;
      logic [63:0] used;
      logic [63:0] number;
      logic [63:0] fee;
      logic [63:0] tip_cap;

      reset                        = 1'b1;
      cycle_count                  = 0;
      fail_count                   = 0;
      results_seen                 = 0;
      model_chain                  = '0;
      plan_chain                   = '0;
      offered_item                 = '0;
      req_bus.valid                = 1'b0;
      req_bus.opcode               = OP_HEADER;
      req_bus.block_number         = '0;
      req_bus.gas_lim              = '0;
      req_bus.gas_spent            = '0;
      req_bus.header_base_fee      = '0;
      req_bus.tx_price             = '0;
      req_bus.max_fee_per_gas      = '0;
      req_bus.max_priority_per_gas = '0;
      rsp_bus.ready                = 1'b0;

      // directed: tips at the extremes, zero target, mismatches, saturation, wrap
      queue_item(tx_item(OP_LEGACY, '0, rand64(), rand64()));
      queue_item(tx_item(OP_LEGACY, ALL_ONES, rand64(), rand64()));
      queue_item(tx_item(OP_DYNAMIC, rand64(), ALL_ONES, ALL_ONES));
      queue_item(tx_item(OP_DYNAMIC, rand64(), 64'd1000, 64'd7));
      queue_item(tx_item(OP_BLOB, ALL_ONES, ALL_ONES, ALL_ONES));
      queue_item(header_item('0, '0, '0, '0));
      queue_item(header_item(64'd1, 64'd1, ALL_ONES, plan_chain.cur_fee));
      queue_item(header_item(64'd5, 64'd30_000_000, 64'd15_000_000, 64'd1_000_000_000));
      queue_item(header_item(plan_chain.number + 64'd7, 64'd30_000_000, 64'd30_000_000,
                             plan_chain.cur_fee));
      queue_item(header_item(plan_chain.number, 64'd30_000_000, '0, plan_chain.cur_fee));
      queue_item(tx_item(OP_LEGACY, plan_chain.cur_fee, rand64(), rand64()));
      queue_item(tx_item(OP_DYNAMIC, rand64(), plan_chain.cur_fee - 64'd1, ALL_ONES));
      queue_item(tx_item(OP_DYNAMIC, rand64(), plan_chain.cur_fee + 64'd100, ALL_ONES));
      queue_item(header_item(plan_chain.number, 64'd1000, 64'd600, 64'd1));
      queue_item(header_item(plan_chain.number, 64'd1000, 64'd501, plan_chain.cur_fee));
      queue_item(header_item(plan_chain.number, 64'd2, ALL_ONES, ALL_ONES - 64'd3));
      queue_item(header_item(plan_chain.number, ALL_ONES, ALL_ONES, plan_chain.cur_fee));
      queue_item(header_item(ALL_ONES, ALL_ONES, '0, plan_chain.cur_fee));
      queue_item(header_item(plan_chain.number, 64'd2, 64'd1, plan_chain.cur_fee));
      queue_item(tx_item(OP_BLOB, rand64(), rand64(), rand64()));

      // random: mostly chained headers, some broken ones, transactions in between
      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 40) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)       limit = 64'($urandom_range(0, 1));
            else if (sel < 24) limit = 64'($urandom_range(2, 5000));
            else if (sel < 64) limit = 64'd30_000_000 + 64'($urandom_range(0, 2_000_000));
            else if (sel < 90) limit = rand64();
            else               limit = ALL_ONES - 64'($urandom_range(0, 1000));
            target = limit >> 1;
            sel = $urandom_range(0, 99);
            if (sel < 10)      used = '0;
            else if (sel < 25) used = target;
            else if (sel < 35) used = target + 64'd1;
            else if (sel < 45) used = target - 64'd1;
            else if (sel < 75) used = (limit == ALL_ONES) ? rand64() : rand64() % (limit + 64'd1);
            else if (sel < 90) used = rand64();
            else               used = ALL_ONES - 64'($urandom_range(0, 3));
            sel = $urandom_range(0, 99);
            if (sel < 85)      number = plan_chain.number;
            else if (sel < 92) number = plan_chain.number + 64'($urandom_range(1, 3));
            else               number = rand64();
            sel = $urandom_range(0, 99);
            if (sel < 85)      fee = plan_chain.cur_fee;
            else if (sel < 90) fee = 64'($urandom_range(0, 100));
            else if (sel < 95) fee = rand64();
            else               fee = ALL_ONES - 64'($urandom_range(0, 100));
            queue_item(header_item(number, limit, used, fee));
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 40)      tip_cap = 64'($urandom_range(0, 2000));
            else if (sel < 80) tip_cap = rand64();
            else if (sel < 90) tip_cap = '0;
            else               tip_cap = ALL_ONES;
            queue_item(tx_item(2'($urandom_range(1, 3)), pick_tx_value(plan_chain.cur_fee),
                               pick_tx_value(plan_chain.cur_fee), tip_cap));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("results missing: %0d still expected", expected_results.size());
         fail_count = fail_count + 1;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
